### rtl/nfk_pkg.sv
// Shared constants, types and the byte-mix function for the normalized path key unit.
package nfk_pkg;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [31:0] KEY_ZERO_SUB = 32'd1;
	localparam logic [2:0] LEN_SAT = 3'd5;
	localparam logic [2:0] HOLD_DEPTH = 3'd4;

	// Controller to datapath commands
	typedef struct packed {
		logic take;    // accepted transaction carries a character
		logic arm;     // latch flush count for the ended path
		logic step;    // mix one held byte during flush
		logic finish;  // load key register and clear path state
	} nfk_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic rem_zero;  // no held bytes left to mix
	} nfk_status_t;

	// Normalize one byte and do one FNV-1a step
	function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] c);
		logic [7:0] v;
		v = c;
		if (v == 8'h2F) v = 8'h5C;
		if (v >= 8'h41 && v <= 8'h5A) v = v + 8'h20;
		fnv_mix = (h ^ {24'd0, v}) * FNV_PRIME;
	endfunction

endpackage

### rtl/nfk_ctrl.sv
// Controller state machine: input acceptance, flush sequencing and output valid.
module nfk_ctrl import nfk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        no_char,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	input  nfk_status_t status,
	output nfk_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ARM,
		ST_FLUSH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   in_fire;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Command decode
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:  cmd.take = in_fire && !no_char;
			ST_ARM:   cmd.arm = 1'b1;
			ST_FLUSH: begin
				cmd.step   = !status.rem_zero;
				cmd.finish = status.rem_zero && out_free;
			end
			default:  cmd = '0;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE:  if (in_fire && last) state_q <= ST_ARM;
				ST_ARM:   state_q <= ST_FLUSH;
				ST_FLUSH: if (cmd.finish) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/nfk_dp.sv
// Datapath: running hash, held byte window, length count, flush counter and key register.
module nfk_dp import nfk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  path_byte,
	input  nfk_cmd_t    cmd,
	output nfk_status_t status,
	output logic [31:0] key
);

	logic [31:0] hash_q;
	logic [7:0]  held_q [4];
	logic [2:0]  len_q;
	logic [2:0]  rem_q;
	logic [31:0] key_q;
	logic [31:0] mixed;
	logic        is_spr;
	logic        len_full;

	assign len_full = (len_q >= HOLD_DEPTH);
	assign mixed    = fnv_mix(hash_q, held_q[0]);

	// Raw ".spr" tail, either case for the letters
	assign is_spr = (held_q[0] == 8'h2E) &&
		(held_q[1] == 8'h73 || held_q[1] == 8'h53) &&
		(held_q[2] == 8'h70 || held_q[2] == 8'h50) &&
		(held_q[3] == 8'h72 || held_q[3] == 8'h52);

	assign status.rem_zero = (rem_q == 3'd0);
	assign key = key_q;

	// Hash, length and flush count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= FNV_BASIS;
			len_q  <= 3'd0;
			rem_q  <= 3'd0;
		end else begin
			if (cmd.take) begin
				if (len_full) hash_q <= mixed;
				if (len_q < LEN_SAT) len_q <= len_q + 3'd1;
			end
			if (cmd.arm) begin
				if (len_q == 3'd0 || (len_q > HOLD_DEPTH && is_spr)) begin
					rem_q <= 3'd0;
				end else if (len_q > HOLD_DEPTH) begin
					rem_q <= HOLD_DEPTH;
				end else begin
					rem_q <= len_q;
				end
			end
			if (cmd.step) begin
				hash_q <= mixed;
				rem_q  <= rem_q - 3'd1;
			end
			if (cmd.finish) begin
				hash_q <= FNV_BASIS;
				len_q  <= 3'd0;
			end
		end
	end

	// Held byte window, oldest first
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			if (len_full) begin
				held_q[0] <= held_q[1];
				held_q[1] <= held_q[2];
				held_q[2] <= held_q[3];
				held_q[3] <= path_byte;
			end else begin
				held_q[len_q[1:0]] <= path_byte;
			end
		end else if (cmd.step) begin
			held_q[0] <= held_q[1];
			held_q[1] <= held_q[2];
			held_q[2] <= held_q[3];
		end
	end

	// Key register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (len_q == 3'd0) begin
				key_q <= 32'd0;
			end else if (hash_q == 32'd0) begin
				key_q <= KEY_ZERO_SUB;
			end else begin
				key_q <= hash_q;
			end
		end
	end

endmodule

### rtl/normalized_path_fnv1a_key_unit.sv
// Normalized path FNV-1a key unit: one byte per cycle outside the path-end flush, key at path end.
// Throughput: one path byte per cycle while a path streams in; one multiply per byte.
// Path end: the last transaction is followed by an arm state and a flush state that mixes
// each held byte (up to four), then the key loads into the output register once it is free.
// No input is taken from the last transaction until the key loads.
// Reset (arst_n low, asynchronous): idle, no key pending, hash at the offset basis.
module normalized_path_fnv1a_key_unit import nfk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  path_byte,
	input  logic        no_char,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] key
);

	nfk_cmd_t    cmd;
	nfk_status_t status;

	nfk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.no_char   (no_char),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	nfk_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.path_byte (path_byte),
		.cmd       (cmd),
		.status    (status),
		.key       (key)
	);

	// At most one command per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.arm, cmd.step, cmd.finish}))
		else $error("more than one datapath command in a cycle");

	// Key loads only once all held bytes are mixed
	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> status.rem_zero)
		else $error("key loaded before flush done");

	// A loaded key is presented next cycle
	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid)
		else $error("key loaded but not presented");

	// Ending a path stops input until the flush finishes
	a_last_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && last) |=> !in_ready)
		else $error("input taken while path flush pending");

endmodule

### sim/nfk_key_checker.sv
// Scoreboard for the normalized path key unit: predicts each key and checks the key channel.
module nfk_key_checker import nfk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  path_byte,
	input  logic        no_char,
	input  logic        last,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] key,
	output int          mismatches,
	output int          keys_owed
);

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] LC_S      = 8'h73;
	localparam logic [7:0] LC_P      = 8'h70;
	localparam logic [7:0] LC_R      = 8'h72;
	localparam logic [7:0] UC_A      = 8'h41;
	localparam logic [7:0] UC_Z      = 8'h5A;
	localparam logic [7:0] CASE_BIT  = 8'h20;

	// Predicted path state: hash of bytes already released, raw tail held back
	logic [31:0] path_hash;
	logic [7:0]  tail_bytes [4];
	logic [2:0]  bytes_seen;
	logic [31:0] keys_due [$];
	logic [31:0] want_key;
	int          err_total;

	function automatic logic [7:0] normalize(input logic [7:0] c);
		if (c == CH_SLASH)
			return CH_BSLASH;
		if (c >= UC_A && c <= UC_Z)
			return c | CASE_BIT;
		return c;
	endfunction

	function automatic logic [31:0] hash_in(input logic [31:0] h, input logic [7:0] c);
		logic [31:0] folded;
		folded = h ^ {24'd0, normalize(c)};
		return folded * FNV_PRIME;
	endfunction

	// Raw tail reads ".spr" in any letter case
	function automatic bit sprite_tail();
		return tail_bytes[0] == CH_DOT &&
			(tail_bytes[1] | CASE_BIT) == LC_S &&
			(tail_bytes[2] | CASE_BIT) == LC_P &&
			(tail_bytes[3] | CASE_BIT) == LC_R;
	endfunction

	function automatic logic [31:0] close_path();
		logic [31:0] h;
		int          n;
		h = path_hash;
		if (bytes_seen == 3'd0)
			return 32'd0;
		n = (bytes_seen > HOLD_DEPTH) ? 4 : int'(bytes_seen);
		if (!(bytes_seen > HOLD_DEPTH && sprite_tail()))
			for (int i = 0; i < n; i++)
				h = hash_in(h, tail_bytes[i]);
		return (h == 32'd0) ? KEY_ZERO_SUB : h;
	endfunction

	task automatic clear_path();
		path_hash = FNV_BASIS;
		for (int i = 0; i < 4; i++)
			tail_bytes[i] = 8'd0;
		bytes_seen = 3'd0;
	endtask

	// Oldest held byte is released into the hash once four are waiting
	task automatic take_char(input logic [7:0] c);
		if (bytes_seen >= HOLD_DEPTH) begin
			path_hash = hash_in(path_hash, tail_bytes[0]);
			tail_bytes[0] = tail_bytes[1];
			tail_bytes[1] = tail_bytes[2];
			tail_bytes[2] = tail_bytes[3];
			tail_bytes[3] = c;
		end else begin
			tail_bytes[bytes_seen[1:0]] = c;
		end
		if (bytes_seen < LEN_SAT)
			bytes_seen = bytes_seen + 3'd1;
	endtask

	// Input transactions feed the predictor, key transactions are checked in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_path();
			keys_due.delete();
			err_total = 0;
			mismatches <= 0;
			keys_owed <= 0;
		end else begin
			if (in_valid && in_ready) begin
				if (!no_char)
					take_char(path_byte);
				if (last) begin
					keys_due.push_back(close_path());
					clear_path();
				end
			end
			if (out_valid && out_ready) begin
				if (keys_due.size() == 0) begin
					$error("key: expected none, actual %h", key);
					err_total++;
				end else begin
					want_key = keys_due.pop_front();
					if (key !== want_key) begin
						$error("key: expected %h, actual %h", want_key, key);
						err_total++;
					end
				end
			end
			mismatches <= err_total;
			keys_owed <= keys_due.size();
		end
	end

endmodule

### sim/normalized_path_fnv1a_key_unit_tb.sv
// Top of the path key unit testbench: clock, reset, path stimulus, key sink and verdict.
module normalized_path_fnv1a_key_unit_tb;

	localparam int ITEM_TARGET   = 850;
	localparam int CALM_AFTER    = 750;
	localparam int SQUEEZE_AT    = 300;
	localparam int PAUSE_AT      = 560;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 16;

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] LC_A      = 8'h61;
	localparam logic [7:0] LC_S      = 8'h73;
	localparam logic [7:0] LC_P      = 8'h70;
	localparam logic [7:0] LC_R      = 8'h72;
	localparam logic [7:0] UC_A      = 8'h41;
	localparam logic [7:0] CASE_BIT  = 8'h20;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  path_byte = 8'd0;
	logic        no_char = 1'b0;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] key;

	int mismatches;
	int keys_owed;
	int items_sent = 0;
	int quiet_cycles = 0;
	int gap_odds = 1;
	bit sender_calm = 1'b0;
	bit sink_calm = 1'b0;
	bit long_hold = 1'b0;
	bit hold_taken = 1'b0;

	normalized_path_fnv1a_key_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.path_byte (path_byte),
		.no_char   (no_char),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.key       (key)
	);

	nfk_key_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.path_byte  (path_byte),
		.no_char    (no_char),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key        (key),
		.mismatches (mismatches),
		.keys_owed  (keys_owed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: too long without any transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Key sink: ready runs, short stall bursts, and one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold && !hold_taken) begin
				hold_taken = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(0, 20)) @(posedge clk);
			end
		end
	end

	// One input transaction, optionally after an idle burst
	task automatic offer(input logic [7:0] b, input logic nc, input logic lst);
		if (!sender_calm && gap_odds != 0 && $urandom_range(0, gap_odds * 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		path_byte <= b;
		no_char <= nc;
		last <= lst;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (!nc || lst)
			items_sent++;
	endtask

	// Sender stops until every predicted key has been taken
	task automatic wait_for_keys();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (keys_owed != 0);
	endtask

	function automatic logic [7:0] random_char();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return LC_A + 8'($urandom_range(0, 25));
			4, 5:       return UC_A + 8'($urandom_range(0, 25));
			6:          return $urandom_range(0, 1) ? CH_SLASH : CH_BSLASH;
			7:          return CH_DOT;
			8:          return 8'($urandom_range(1, 255));
			default:    return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Path of n characters, optionally ending in ".spr" (random case, sometimes spoiled)
	task automatic send_path(input int n, input bit ext, input bit dense);
		logic [7:0] ch;
		logic [7:0] ext_chars [4];
		int         spoil;
		int         pos;
		bit         marker_end;
		ext_chars = '{CH_DOT, LC_S, LC_P, LC_R};
		gap_odds = dense ? 0 : $urandom_range(0, 3);
		marker_end = ($urandom_range(0, 4) == 0);
		spoil = (ext && $urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : -1;
		if (n == 0) begin
			offer(8'($urandom_range(0, 255)), 1'b1, 1'b1);
		end else begin
			for (int i = 0; i < n; i++) begin
				pos = i - (n - 4);
				if (ext && pos >= 0 && pos != spoil) begin
					ch = ext_chars[pos];
					if (pos != 0 && $urandom_range(0, 1))
						ch = ch & ~CASE_BIT;
				end else begin
					ch = random_char();
				end
				// stray transaction without a character
				if ($urandom_range(0, 15) == 0)
					offer(8'($urandom_range(0, 255)), 1'b1, 1'b0);
				offer(ch, 1'b0, (i == n - 1) && !marker_end);
			end
			if (marker_end)
				offer(8'($urandom_range(0, 255)), 1'b1, 1'b1);
		end
	endtask

	initial begin
		int n;
		int r;
		bit squeezed;
		bit paused;
		squeezed = 1'b0;
		paused = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// empty path
		offer(8'hFF, 1'b1, 1'b1);
		// stray item, then one upper-case letter
		offer(8'h5A, 1'b1, 1'b0);
		offer(8'h5A, 1'b0, 1'b1);
		// exactly four bytes: slash, both letter-range neighbors, NUL
		offer(CH_SLASH, 1'b0, 1'b0);
		offer(8'h40, 1'b0, 1'b0);
		offer(8'h5B, 1'b0, 1'b0);
		offer(8'h00, 1'b0, 1'b1);
		// extension dropped from a five-byte path
		offer(8'h78, 1'b0, 1'b0);
		offer(CH_DOT, 1'b0, 1'b0);
		offer(8'h53, 1'b0, 1'b0);
		offer(LC_P, 1'b0, 1'b0);
		offer(8'h52, 1'b0, 1'b1);
		// extension alone is four bytes, so it is hashed
		offer(CH_DOT, 1'b0, 1'b0);
		offer(LC_S, 1'b0, 1'b0);
		offer(8'h50, 1'b0, 1'b0);
		offer(LC_R, 1'b0, 1'b1);
		// extension, then the path ends on an item without character
		offer(8'hFF, 1'b0, 1'b0);
		offer(CH_DOT, 1'b0, 1'b0);
		offer(LC_S, 1'b0, 1'b0);
		offer(LC_P, 1'b0, 1'b0);
		offer(LC_R, 1'b0, 1'b0);
		offer(8'h00, 1'b1, 1'b1);
		// mixed bytes, backslash and high half
		offer(UC_A, 1'b0, 1'b0);
		offer(8'h7B, 1'b0, 1'b0);
		offer(CH_BSLASH, 1'b0, 1'b0);
		offer(8'h80, 1'b0, 1'b0);
		offer(8'h01, 1'b0, 1'b1);

		while (items_sent < ITEM_TARGET) begin
			if (items_sent >= CALM_AFTER && !sender_calm) begin
				sender_calm = 1'b1;
				sink_calm <= 1'b1;
			end
			// sink holds off while short paths keep coming, then drain
			if (!squeezed && items_sent >= SQUEEZE_AT) begin
				squeezed = 1'b1;
				long_hold <= 1'b1;
				for (int k = 0; k < 12; k++)
					send_path($urandom_range(1, 6), $urandom_range(0, 1), 1'b1);
				wait_for_keys();
			end
			if (!paused && items_sent >= PAUSE_AT) begin
				paused = 1'b1;
				wait_for_keys();
			end
			r = $urandom_range(0, 19);
			if (r == 0)
				n = 0;
			else if (r < 14)
				n = $urandom_range(1, 8);
			else if (r < 18)
				n = $urandom_range(9, 16);
			else
				n = $urandom_range(17, 40);
			send_path(n, $urandom_range(0, 2) == 0, 1'b0);
		end

		wait_for_keys();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && keys_owed == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
